@@ sv/rti_pkg.sv @@
// shared widths, types and register codes for the ray / triangle intersection test
package rti_pkg;

	// coordinate and intermediate widths, all exact (no rounding anywhere)
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;            // edge and ray vectors
	localparam int PROD_W     = 2 * DIFF_W;             // one cross product term
	localparam int CROSS_W    = PROD_W + 1;             // cross product component
	localparam int LO_W       = (CROSS_W + 1) / 2;      // low slice of a cross component
	localparam int HI_W       = CROSS_W - LO_W;         // high (signed) slice
	localparam int HI_PART_W  = DIFF_W + HI_W;
	localparam int LO_PART_W  = DIFF_W + LO_W + 1;
	localparam int DOT_PROD_W = DIFF_W + CROSS_W;       // one full dot product term
	localparam int DOT_W      = DOT_PROD_W + 2;         // sum of three terms
	localparam int EPS_W      = 62;

	localparam int NSTAGE     = 8;
	localparam int NFIELD_IN  = 9;
	localparam int IN_DATA_W  = ((NFIELD_IN * COORD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = EPS_W;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(64'd281474977);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [DOT_W-1:0]   dot_t;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR_X,
		REG_NEAR_Y,
		REG_NEAR_Z,
		REG_FAR_X,
		REG_FAR_Y,
		REG_FAR_Z,
		REG_DET_EPS
	} cfg_reg_t;

endpackage

@@ sv/rti_dot3.sv @@
// three-stage exact dot product of a difference vector with a cross product vector
module rti_dot3 (
	input  logic                    clk,
	input  logic [2:0]              en,      // stage loads: partials, terms, sum
	input  rti_pkg::diff_t          x [3],
	input  rti_pkg::cross_t         y [3],
	output rti_pkg::dot_t           dot
);
	import rti_pkg::*;

	logic signed [HI_PART_W-1:0]  hi_s4 [3];
	logic signed [LO_PART_W-1:0]  lo_s4 [3];
	logic signed [DOT_PROD_W-1:0] term_s5 [3];
	dot_t                         dot_s6;

	// partial products on the high and low slices of each cross component
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				hi_s4[i] <= HI_PART_W'($signed(x[i]))
					* HI_PART_W'($signed(y[i][CROSS_W-1:LO_W]));
				lo_s4[i] <= LO_PART_W'($signed(x[i]))
					* LO_PART_W'($signed({1'b0, y[i][LO_W-1:0]}));
			end
		end
	end

	// recombine the slices into full terms
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				term_s5[i] <= $signed({hi_s4[i], {LO_W{1'b0}}}) + DOT_PROD_W'(lo_s4[i]);
			end
		end
	end

	// sum of the three terms
	always_ff @(posedge clk) begin
		if (en[2]) begin
			dot_s6 <= DOT_W'(term_s5[0]) + DOT_W'(term_s5[1]) + DOT_W'(term_s5[2]);
		end
	end

	assign dot = dot_s6;

endmodule

@@ sv/ray_triangle_intersection_test.sv @@
// Ray / triangle crossing test against a pick ray held in configuration registers.
// One triangle is taken per cycle while the output side does not stall, and each gives
// one hit flag; the result passes through eight register stages (differences, cross
// products in two steps, three dot product steps, sign handling, final compare). Empty
// stages close up on a stall, so input keeps being taken while a result waits, until
// every stage is full. All arithmetic is exact; u and v are tested by cross-multiplying
// with the determinant, so there is no divider. The ray is the whole line through the
// near and far points (no range check on t). Write the registers only while idle.
module ray_triangle_intersection_test (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (32 bits each)
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rti_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// output stream: hit (bit 0), zero filled above
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rti_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rti_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rti_pkg::*;

	coord_t             near_q [3];
	coord_t             far_q [3];
	logic [EPS_W-1:0]   det_epsilon_q;

	logic [NSTAGE-1:0]  valid_q;
	logic [NSTAGE-1:0]  stage_en;
	logic [NSTAGE-1:0]  valid_in;

	coord_t             v0 [3];
	coord_t             v1 [3];
	coord_t             v2 [3];

	diff_t              d_s1 [3];
	diff_t              e1_s1 [3];
	diff_t              e2_s1 [3];
	diff_t              s_s1 [3];

	diff_t              d_s2 [3];
	diff_t              e1_s2 [3];
	diff_t              s_s2 [3];
	prod_t              pp_s2 [6];
	prod_t              qp_s2 [6];

	diff_t              d_s3 [3];
	diff_t              e1_s3 [3];
	diff_t              s_s3 [3];
	cross_t             p_s3 [3];
	cross_t             q_s3 [3];

	dot_t               a_s6;
	dot_t               u_s6;
	dot_t               v_s6;

	dot_t               a_neg;
	dot_t               u_neg;
	dot_t               v_neg;
	logic               det_small;

	dot_t               an_s7;
	dot_t               un_s7;
	dot_t               vn_s7;
	logic               small_s7;

	logic signed [DOT_W:0] uv_sum;
	logic               hit_s8;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				near_q[i] <= '0;
				far_q[i]  <= '0;
			end
			det_epsilon_q <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEAR_X:  near_q[0]     <= cfg_data[COORD_W-1:0];
				REG_NEAR_Y:  near_q[1]     <= cfg_data[COORD_W-1:0];
				REG_NEAR_Z:  near_q[2]     <= cfg_data[COORD_W-1:0];
				REG_FAR_X:   far_q[0]      <= cfg_data[COORD_W-1:0];
				REG_FAR_Y:   far_q[1]      <= cfg_data[COORD_W-1:0];
				REG_FAR_Z:   far_q[2]      <= cfg_data[COORD_W-1:0];
				REG_DET_EPS: det_epsilon_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage loads: a stage moves when it is empty or the one after it moves
	always_comb begin
		stage_en[NSTAGE-1] = !valid_q[NSTAGE-1] || m_axis_tready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			stage_en[k] = !valid_q[k] || stage_en[k+1];
		end
	end

	assign valid_in      = {valid_q[NSTAGE-2:0], s_axis_tvalid};
	assign s_axis_tready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (stage_en[k]) begin
					valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	// unpack the vertices
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v0[i] = s_axis_tdata[COORD_W*i +: COORD_W];
			v1[i] = s_axis_tdata[COORD_W*(3+i) +: COORD_W];
			v2[i] = s_axis_tdata[COORD_W*(6+i) +: COORD_W];
		end
	end

	// stage 1: ray direction, edges and offset of the near point
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DIFF_W'(far_q[i]) - DIFF_W'(near_q[i]);
				e1_s1[i] <= DIFF_W'(v1[i]) - DIFF_W'(v0[i]);
				e2_s1[i] <= DIFF_W'(v2[i]) - DIFF_W'(v0[i]);
				s_s1[i]  <= DIFF_W'(near_q[i]) - DIFF_W'(v0[i]);
			end
		end
	end

	// stage 2: cross product terms of d x e2 and s x e1
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			pp_s2[0] <= PROD_W'(d_s1[1]) * PROD_W'(e2_s1[2]);
			pp_s2[1] <= PROD_W'(d_s1[2]) * PROD_W'(e2_s1[1]);
			pp_s2[2] <= PROD_W'(d_s1[2]) * PROD_W'(e2_s1[0]);
			pp_s2[3] <= PROD_W'(d_s1[0]) * PROD_W'(e2_s1[2]);
			pp_s2[4] <= PROD_W'(d_s1[0]) * PROD_W'(e2_s1[1]);
			pp_s2[5] <= PROD_W'(d_s1[1]) * PROD_W'(e2_s1[0]);
			qp_s2[0] <= PROD_W'(s_s1[1]) * PROD_W'(e1_s1[2]);
			qp_s2[1] <= PROD_W'(s_s1[2]) * PROD_W'(e1_s1[1]);
			qp_s2[2] <= PROD_W'(s_s1[2]) * PROD_W'(e1_s1[0]);
			qp_s2[3] <= PROD_W'(s_s1[0]) * PROD_W'(e1_s1[2]);
			qp_s2[4] <= PROD_W'(s_s1[0]) * PROD_W'(e1_s1[1]);
			qp_s2[5] <= PROD_W'(s_s1[1]) * PROD_W'(e1_s1[0]);
			d_s2  <= d_s1;
			e1_s2 <= e1_s1;
			s_s2  <= s_s1;
		end
	end

	// stage 3: cross product components
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= CROSS_W'(pp_s2[2*i]) - CROSS_W'(pp_s2[2*i+1]);
				q_s3[i] <= CROSS_W'(qp_s2[2*i]) - CROSS_W'(qp_s2[2*i+1]);
			end
			d_s3  <= d_s2;
			e1_s3 <= e1_s2;
			s_s3  <= s_s2;
		end
	end

	// stages 4 to 6: determinant and the two scaled barycentrics
	rti_dot3 u_dot_a (
		.clk (clk),
		.en  (stage_en[5:3]),
		.x   (e1_s3),
		.y   (p_s3),
		.dot (a_s6)
	);

	rti_dot3 u_dot_u (
		.clk (clk),
		.en  (stage_en[5:3]),
		.x   (s_s3),
		.y   (p_s3),
		.dot (u_s6)
	);

	rti_dot3 u_dot_v (
		.clk (clk),
		.en  (stage_en[5:3]),
		.x   (d_s3),
		.y   (q_s3),
		.dot (v_s6)
	);

	// stage 7: fold the sign of the determinant in, near parallel check
	always_comb begin
		a_neg     = a_s6[DOT_W-1] ? -a_s6 : a_s6;
		u_neg     = a_s6[DOT_W-1] ? -u_s6 : u_s6;
		v_neg     = a_s6[DOT_W-1] ? -v_s6 : v_s6;
		det_small = (a_s6 == '0) || (a_neg < $signed(DOT_W'(det_epsilon_q)));
	end

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			an_s7    <= a_neg;
			un_s7    <= u_neg;
			vn_s7    <= v_neg;
			small_s7 <= det_small;
		end
	end

	// stage 8: inside test on u and v, edges count as hits
	assign uv_sum = (DOT_W+1)'(un_s7) + (DOT_W+1)'(vn_s7);

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			hit_s8 <= !small_s7 && !un_s7[DOT_W-1] && !(an_s7 < un_s7)
				&& !vn_s7[DOT_W-1] && !((DOT_W+1)'(an_s7) < uv_sum);
		end
	end

	assign m_axis_tvalid = valid_q[NSTAGE-1];
	assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, hit_s8};

	// a near parallel triangle never reports a hit
	a_small_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[6] && stage_en[7] && small_s7) |=> !hit_s8)
		else $error("near parallel triangle reported as hit");

	// the folded determinant is never negative
	a_abs_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[6] |-> !an_s7[DOT_W-1])
		else $error("folded determinant negative");

	// a held stage keeps its item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[2] && !stage_en[2]) |=> valid_q[2])
		else $error("stalled stage lost its item");

	// a stage only fills from the stage before it
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q[4]) |-> $past(valid_q[3]))
		else $error("stage filled without an upstream item");

endmodule
